// ===== design/boris_particle_push_core_macros.svh =====
// assertion helpers for the rtl
`ifndef BORIS_PARTICLE_PUSH_CORE_MACROS_SVH
`define BORIS_PARTICLE_PUSH_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, checked out of reset
`define BPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== design/bpp_pkg.sv =====
`default_nettype none
package bpp_pkg;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WAIT,
        ST_PUB
    } t_state;

    typedef enum logic [2:0] {
        K_LDF,
        K_LDONE,
        K_MOV,
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_END
    } t_kind;

    typedef logic [5:0] t_slot;
    typedef logic [6:0] t_pc;

    typedef struct packed {
        t_kind kind;
        t_slot dst;
        t_slot a;
        t_slot b;
    } t_uop;

    typedef struct packed {
        t_slot ra;
        t_slot rb;
        t_kind kind;
        t_slot dst;
        logic  capture;
        logic  wr_alu;
        logic  start_mul;
        logic  start_div;
        logic  wr_unit;
        logic  publish;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_dp_sts;

    // register file slots; config registers sit at their own index
    localparam t_slot A_K    = 6'd0;
    localparam t_slot A_DT   = 6'd1;
    localparam t_slot A_S0   = 6'd2;
    localparam t_slot A_PX   = 6'd8;
    localparam t_slot A_PY   = 6'd9;
    localparam t_slot A_PZ   = 6'd10;
    localparam t_slot A_VX   = 6'd11;
    localparam t_slot A_VY   = 6'd12;
    localparam t_slot A_VZ   = 6'd13;
    localparam t_slot A_FEX  = 6'd14;
    localparam t_slot A_FEY  = 6'd15;
    localparam t_slot A_FEZ  = 6'd16;
    localparam t_slot A_FBX  = 6'd17;
    localparam t_slot A_FBY  = 6'd18;
    localparam t_slot A_FBZ  = 6'd19;
    localparam t_slot A_KEX  = 6'd20;
    localparam t_slot A_KEY  = 6'd21;
    localparam t_slot A_KEZ  = 6'd22;
    localparam t_slot A_MX   = 6'd23;
    localparam t_slot A_MY   = 6'd24;
    localparam t_slot A_MZ   = 6'd25;
    localparam t_slot A_TX   = 6'd26;
    localparam t_slot A_TY   = 6'd27;
    localparam t_slot A_TZ   = 6'd28;
    localparam t_slot A_T2   = 6'd29;
    localparam t_slot A_DEN  = 6'd30;
    localparam t_slot A_SX   = 6'd31;
    localparam t_slot A_SY   = 6'd32;
    localparam t_slot A_SZ   = 6'd33;
    localparam t_slot A_QX   = 6'd34;
    localparam t_slot A_QY   = 6'd35;
    localparam t_slot A_QZ   = 6'd36;
    localparam t_slot A_TA   = 6'd37;
    localparam t_slot A_TB   = 6'd38;
    localparam t_slot A_ONE  = 6'd39;

    localparam int   N_STATE    = 6;
    localparam t_pc  PC_RESTART = 7'd62;
    localparam t_pc  PC_LAST    = 7'd68;

    function automatic logic [63:0] apply_sign(input logic [63:0] mag, input logic neg);
        logic [63:0] res;
        if (!neg) begin
            res = mag[63] ? SMAX : mag;
        end else begin
            res = (mag > SMIN) ? SMIN : (~mag + 64'd1);
        end
        return res;
    endfunction

    function automatic t_uop mk(input t_kind k, input t_slot d, input t_slot a, input t_slot b);
        t_uop u;
        u.kind = k;
        u.dst  = d;
        u.a    = a;
        u.b    = b;
        return u;
    endfunction

    // step program from 0, restart program from PC_RESTART
    function automatic t_uop uop_rom(input t_pc pc);
        t_uop u;
        case (pc)
            7'd0:  u = mk(K_LDF, A_FEX, 6'd0, 6'd0);
            7'd1:  u = mk(K_LDF, A_FEY, 6'd1, 6'd0);
            7'd2:  u = mk(K_LDF, A_FEZ, 6'd2, 6'd0);
            7'd3:  u = mk(K_LDF, A_FBX, 6'd3, 6'd0);
            7'd4:  u = mk(K_LDF, A_FBY, 6'd4, 6'd0);
            7'd5:  u = mk(K_LDF, A_FBZ, 6'd5, 6'd0);
            7'd6:  u = mk(K_MUL, A_KEX, A_K, A_FEX);
            7'd7:  u = mk(K_MUL, A_KEY, A_K, A_FEY);
            7'd8:  u = mk(K_MUL, A_KEZ, A_K, A_FEZ);
            7'd9:  u = mk(K_ADD, A_MX, A_VX, A_KEX);
            7'd10: u = mk(K_ADD, A_MY, A_VY, A_KEY);
            7'd11: u = mk(K_ADD, A_MZ, A_VZ, A_KEZ);
            7'd12: u = mk(K_MUL, A_TX, A_K, A_FBX);
            7'd13: u = mk(K_MUL, A_TY, A_K, A_FBY);
            7'd14: u = mk(K_MUL, A_TZ, A_K, A_FBZ);
            7'd15: u = mk(K_MUL, A_TA, A_TX, A_TX);
            7'd16: u = mk(K_MUL, A_TB, A_TY, A_TY);
            7'd17: u = mk(K_ADD, A_T2, A_TA, A_TB);
            7'd18: u = mk(K_MUL, A_TA, A_TZ, A_TZ);
            7'd19: u = mk(K_ADD, A_T2, A_T2, A_TA);
            7'd20: u = mk(K_LDONE, A_ONE, A_ONE, A_ONE);
            7'd21: u = mk(K_ADD, A_DEN, A_ONE, A_T2);
            7'd22: u = mk(K_ADD, A_TA, A_TX, A_TX);
            7'd23: u = mk(K_DIV, A_SX, A_TA, A_DEN);
            7'd24: u = mk(K_ADD, A_TA, A_TY, A_TY);
            7'd25: u = mk(K_DIV, A_SY, A_TA, A_DEN);
            7'd26: u = mk(K_ADD, A_TA, A_TZ, A_TZ);
            7'd27: u = mk(K_DIV, A_SZ, A_TA, A_DEN);
            // v' = v- + v- x t
            7'd28: u = mk(K_MUL, A_TA, A_MY, A_TZ);
            7'd29: u = mk(K_MUL, A_TB, A_MZ, A_TY);
            7'd30: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd31: u = mk(K_ADD, A_QX, A_MX, A_TA);
            7'd32: u = mk(K_MUL, A_TA, A_MZ, A_TX);
            7'd33: u = mk(K_MUL, A_TB, A_MX, A_TZ);
            7'd34: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd35: u = mk(K_ADD, A_QY, A_MY, A_TA);
            7'd36: u = mk(K_MUL, A_TA, A_MX, A_TY);
            7'd37: u = mk(K_MUL, A_TB, A_MY, A_TX);
            7'd38: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd39: u = mk(K_ADD, A_QZ, A_MZ, A_TA);
            // v+ = v- + v' x s, then second half kick and position update
            7'd40: u = mk(K_MUL, A_TA, A_QY, A_SZ);
            7'd41: u = mk(K_MUL, A_TB, A_QZ, A_SY);
            7'd42: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd43: u = mk(K_ADD, A_TA, A_MX, A_TA);
            7'd44: u = mk(K_ADD, A_VX, A_TA, A_KEX);
            7'd45: u = mk(K_MUL, A_TA, A_QZ, A_SX);
            7'd46: u = mk(K_MUL, A_TB, A_QX, A_SZ);
            7'd47: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd48: u = mk(K_ADD, A_TA, A_MY, A_TA);
            7'd49: u = mk(K_ADD, A_VY, A_TA, A_KEY);
            7'd50: u = mk(K_MUL, A_TA, A_QX, A_SY);
            7'd51: u = mk(K_MUL, A_TB, A_QY, A_SX);
            7'd52: u = mk(K_SUB, A_TA, A_TA, A_TB);
            7'd53: u = mk(K_ADD, A_TA, A_MZ, A_TA);
            7'd54: u = mk(K_ADD, A_VZ, A_TA, A_KEZ);
            7'd55: u = mk(K_MUL, A_TA, A_VX, A_DT);
            7'd56: u = mk(K_ADD, A_PX, A_PX, A_TA);
            7'd57: u = mk(K_MUL, A_TA, A_VY, A_DT);
            7'd58: u = mk(K_ADD, A_PY, A_PY, A_TA);
            7'd59: u = mk(K_MUL, A_TA, A_VZ, A_DT);
            7'd60: u = mk(K_ADD, A_PZ, A_PZ, A_TA);
            7'd61: u = mk(K_END, A_K, A_K, A_K);
            7'd62: u = mk(K_MOV, A_PX, A_S0, A_S0);
            7'd63: u = mk(K_MOV, A_PY, A_S0 + 6'd1, A_S0);
            7'd64: u = mk(K_MOV, A_PZ, A_S0 + 6'd2, A_S0);
            7'd65: u = mk(K_MOV, A_VX, A_S0 + 6'd3, A_S0);
            7'd66: u = mk(K_MOV, A_VY, A_S0 + 6'd4, A_S0);
            7'd67: u = mk(K_MOV, A_VZ, A_S0 + 6'd5, A_S0);
            default: u = mk(K_END, A_K, A_K, A_K);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== design/bpp_mul.sv =====
`default_nettype none
module bpp_mul
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_res
);

    localparam logic [127:0] HALF = 128'(1) << (FRAC_BITS - 1);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [63:0]  r_p;
    logic [127:0] r_acc;
    logic [63:0]  r_res;
    logic         r_done;

    logic [31:0]  w_ah, w_bh;
    logic [1:0]   w_pidx;
    logic [127:0] w_pshift;
    logic [63:0]  w_rl;
    logic         w_ovf;

    assign w_ah   = r_cnt[0] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh   = r_cnt[1] ? r_mb[63:32] : r_mb[31:0];
    assign w_pidx = r_cnt[1:0] - 2'd1;
    assign w_rl   = r_acc[FRAC_BITS +: 64];
    assign w_ovf  = |(r_acc >> (FRAC_BITS + 64));

    always_comb begin
        case (w_pidx)
            2'd0:    w_pshift = {64'd0, r_p};
            2'd1:    w_pshift = {32'd0, r_p, 32'd0};
            2'd2:    w_pshift = {32'd0, r_p, 32'd0};
            default: w_pshift = {r_p, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial products one cycle, accumulate the next, then round and saturate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? (~i_a + 64'd1) : i_a;
            r_mb  <= i_b[63] ? (~i_b + 64'd1) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_p <= {32'd0, w_ah} * {32'd0, w_bh};
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pshift;
            end else if (r_cnt == 3'd5) begin
                r_acc <= r_acc + HALF;
            end else if (r_cnt == 3'd6) begin
                r_res <= w_ovf ? (r_neg ? SMIN : SMAX) : apply_sign(w_rl, r_neg);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== design/bpp_div.sv =====
`default_nettype none
module bpp_div
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_res
);

    localparam logic [7:0] STEPS = 8'd128;

    logic         r_busy;
    logic [7:0]   r_cnt;
    logic [127:0] r_num;
    logic [63:0]  r_den, r_r, r_q, r_res;
    logic         r_neg;
    logic         r_done;

    logic [63:0]  w_mag;
    logic [64:0]  w_rr;
    logic         w_ge;

    assign w_mag = i_num[63] ? (~i_num + 64'd1) : i_num;
    assign w_rr  = {r_r, r_num[127]};
    assign w_ge  = w_rr >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 8'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == STEPS) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= ({64'd0, w_mag} << FRAC_BITS) + {65'd0, i_den[63:1]};
            r_den <= i_den;
            r_neg <= i_num[63];
            r_r   <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_cnt < STEPS) begin
                r_num <= r_num << 1;
                r_r   <= w_ge ? 64'(w_rr - {1'b0, r_den}) : w_rr[63:0];
                r_q   <= {r_q[62:0], w_ge};
            end else begin
                r_res <= apply_sign(r_q, r_neg);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

// ===== design/bpp_datapath.sv =====
`default_nettype none
module bpp_datapath
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_sts           o_sts,
    input  wire logic [383:0] i_fields,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [63:0]  i_cfg_data,
    output logic [383:0]      o_out
);

    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    logic [63:0]  r_mem [0:63];
    logic [15:0]  r_vld;
    logic [63:0]  r_rda, r_rdb;
    logic [63:0]  r_fld [0:5];
    logic [63:0]  r_st  [0:5];
    logic [383:0] r_out;

    logic         w_we;
    t_slot        w_wa;
    logic [63:0]  w_wd;
    logic [63:0]  w_alu, w_fsel;
    logic         w_ucw;
    logic [63:0]  w_mul_res, w_div_res;
    logic         w_mul_done, w_div_done;
    logic [5:0]   w_sidx;

    bpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_mul),
        .i_a     (r_rda),
        .i_b     (r_rdb),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (r_rda),
        .i_den   (r_rdb),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    always_comb begin
        case (i_cmd.ra[2:0])
            3'd0:    w_fsel = r_fld[0];
            3'd1:    w_fsel = r_fld[1];
            3'd2:    w_fsel = r_fld[2];
            3'd3:    w_fsel = r_fld[3];
            3'd4:    w_fsel = r_fld[4];
            3'd5:    w_fsel = r_fld[5];
            default: w_fsel = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.kind)
            K_LDF:   w_alu = w_fsel;
            K_LDONE: w_alu = ONE;
            K_MOV:   w_alu = r_rda;
            K_ADD:   w_alu = sadd(r_rda, r_rdb);
            K_SUB:   w_alu = ssub(r_rda, r_rdb);
            default: w_alu = r_rda;
        endcase
    end

    assign w_ucw = i_cmd.wr_alu | i_cmd.wr_unit;

    always_comb begin
        if (w_ucw) begin
            w_we = 1'b1;
            w_wa = i_cmd.dst;
            if (i_cmd.wr_unit) begin
                w_wd = w_div_done ? w_div_res : w_mul_res;
            end else begin
                w_wd = w_alu;
            end
        end else begin
            w_we = i_cfg_we;
            w_wa = {3'd0, i_cfg_idx};
            // the step register keeps its low 63 bits
            w_wd = (i_cfg_idx == 3'(A_DT)) ? (i_cfg_data & SMAX) : i_cfg_data;
        end
    end

    assign w_sidx = w_wa - A_PX;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rda <= (i_cmd.ra[5:4] == 2'd0 && !r_vld[i_cmd.ra[3:0]]) ? 64'd0 : r_mem[i_cmd.ra];
        r_rdb <= (i_cmd.rb[5:4] == 2'd0 && !r_vld[i_cmd.rb[3:0]]) ? 64'd0 : r_mem[i_cmd.rb];
    end

    // slots holding registers and state read as zero until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we && w_wa[5:4] == 2'd0) begin
            r_vld[w_wa[3:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < N_STATE; i++) begin
                r_fld[i] <= i_fields[i*64 +: 64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_STATE; i++) begin
                r_st[i] <= '0;
            end
        end else if (w_ucw && w_wa >= A_PX && w_wa <= A_VZ) begin
            r_st[w_sidx[2:0]] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= {r_st[5], r_st[4], r_st[3], r_st[2], r_st[1], r_st[0]};
        end
    end

    assign o_sts.mul_done = w_mul_done;
    assign o_sts.div_done = w_div_done;
    assign o_out          = r_out;

endmodule
`default_nettype wire

// ===== design/bpp_ctrl.sv =====
`default_nettype none
`include "boris_particle_push_core_macros.svh"
module bpp_ctrl
    import bpp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire logic    i_s_cmd,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    logic   r_ovalid, n_ovalid;
    t_uop   w_uop;

    assign w_uop = uop_rom(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_pc            = r_pc;
        n_ovalid        = r_ovalid && !i_m_tready;
        o_s_tready      = 1'b0;
        o_cmd.ra        = w_uop.a;
        o_cmd.rb        = w_uop.b;
        o_cmd.kind      = w_uop.kind;
        o_cmd.dst       = w_uop.dst;
        o_cmd.capture   = 1'b0;
        o_cmd.wr_alu    = 1'b0;
        o_cmd.start_mul = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.wr_unit   = 1'b0;
        o_cmd.publish   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_pc          = i_s_cmd ? PC_RESTART : '0;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (w_uop.kind)
                    K_END: begin
                        n_state = ST_PUB;
                    end
                    K_MUL: begin
                        o_cmd.start_mul = 1'b1;
                        n_state         = ST_WAIT;
                    end
                    K_DIV: begin
                        o_cmd.start_div = 1'b1;
                        n_state         = ST_WAIT;
                    end
                    default: begin
                        o_cmd.wr_alu = 1'b1;
                        n_pc         = r_pc + 7'd1;
                        n_state      = ST_READ;
                    end
                endcase
            end
            ST_WAIT: begin
                if (i_sts.mul_done || i_sts.div_done) begin
                    o_cmd.wr_unit = 1'b1;
                    n_pc          = r_pc + 7'd1;
                    n_state       = ST_READ;
                end
            end
            ST_PUB: begin
                // hold the result back until the output register frees up
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.publish = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;

    `BPP_ASSERT_IMPL(a_pub_free, i_clk, i_rst_n, o_cmd.publish, !r_ovalid || i_m_tready)
    `BPP_ASSERT_NEXT(a_start_wait, i_clk, i_rst_n, o_cmd.start_mul || o_cmd.start_div, r_state == ST_WAIT)
    `BPP_ASSERT_IMPL(a_pc_range, i_clk, i_rst_n, r_state != ST_IDLE, r_pc <= PC_LAST)
    `BPP_ASSERT_NEXT(a_cap_read, i_clk, i_rst_n, o_cmd.capture, r_state == ST_READ && !o_s_tready)

endmodule
`default_nettype wire

// ===== design/boris_particle_push_core.sv =====
// Boris particle push core: one Boris step of a charged particle per request.
// Input stream: tdata carries the six field components, tuser the command
// (0 advance one step, 1 reload position and velocity from the start registers).
// Output stream: tdata carries new position and velocity, one result per request.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so only while idle; the block itself does not enforce it.
// A microcoded controller runs a register-file datapath with one shared
// multiplier (four 32x32 partial products) and one restoring divider (one
// quotient bit a cycle). An advance request runs 24 products, 3 divisions for
// s and 34 load, add and sub steps; the three divisions take most of its time.
// A new request is taken only once the previous one has finished its program.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and computed, and its result waits until the
// output register is emptied.
// Reset makes the configuration registers and the particle state read as zero.
`default_nettype none
module boris_particle_push_core
    import bpp_pkg::*;
#(
    parameter int FRAC_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // field_ex, field_ey, field_ez, field_bx, field_by, field_bz
    input  wire logic [383:0] i_s_tdata,
    // cmd
    input  wire logic         i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // out_x, out_y, out_z, out_vx, out_vy, out_vz
    output logic [383:0]      o_m_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [63:0]  i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_cmd    (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    bpp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_fields   (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_m_tdata)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_boris_particle_push_core.sv =====
`timescale 1ns / 1ps
module tb_boris_particle_push_core;
    import bpp_pkg::*;

    localparam int FRAC = 32;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

    // configuration register indexes
    typedef enum logic [2:0] {
        R_K, R_DT, R_SX, R_SY, R_SZ, R_SVX, R_SVY, R_SVZ
    } t_reg;

    // request command codes
    typedef enum logic {
        CMD_STEP    = 1'b0,
        CMD_RESTART = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [63:0] vz, vy, vx, z, y, x;
    } t_particle;

    typedef struct {
        t_cmd        cmd;
        logic [63:0] f[6];
        logic        has_exp;
        t_particle   exp_state;
    } t_req_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [383:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [383:0] o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [63:0]  i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    boris_particle_push_core u_top (.*);

    // predictor copy of registers and particle state
    logic [63:0] k_reg, dt_reg;
    logic [63:0] start_reg[6];
    t_particle   particle;
    t_particle   state_queue[$];
    int          errors = 0;

    function automatic logic [63:0] mag64(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg);
        if (!neg) return (m > SMAX) ? SMAX : m;
        return (m > SMIN) ? SMIN : (~m + 64'd1);
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [128:0] p;
        p = {1'b0, mag64(a)} * {65'd0, mag64(b)};
        p = p + (129'd1 << (FRAC - 1));
        p = p >> FRAC;
        if (p[128:64] != 0) return (a[63] ^ b[63]) ? SMIN : SMAX;
        return signed_sat(p[63:0], a[63] ^ b[63]);
    endfunction

    function automatic logic [63:0] qdiv(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] n;
        logic [127:0] q;
        n = ({64'd0, mag64(num)} << FRAC) + {65'd0, den[63:1]};
        q = n / {64'd0, den};
        if (q[127:64] != 0) return num[63] ? SMIN : SMAX;
        return signed_sat(q[63:0], num[63]);
    endfunction

    task automatic write_reg(input t_reg idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            R_K:     k_reg = val;
            R_DT:    dt_reg = val & SMAX;
            default: start_reg[3'(idx - R_SX)] = val;
        endcase
    endtask

    task automatic predict_push(input t_cmd cmd, input logic [63:0] f[6]);
        logic [63:0] kex, key, kez, mx, my, mz, tx, ty, tz, t2, den, sx, sy, sz;
        logic [63:0] px, py, pz, ux, uy, uz;
        if (cmd == CMD_RESTART) begin
            particle = {start_reg[5], start_reg[4], start_reg[3],
                        start_reg[2], start_reg[1], start_reg[0]};
        end else begin
            kex = qmul(k_reg, f[0]); key = qmul(k_reg, f[1]); kez = qmul(k_reg, f[2]);
            mx = add_sat(particle.vx, kex);
            my = add_sat(particle.vy, key);
            mz = add_sat(particle.vz, kez);
            tx = qmul(k_reg, f[3]); ty = qmul(k_reg, f[4]); tz = qmul(k_reg, f[5]);
            t2 = add_sat(add_sat(qmul(tx, tx), qmul(ty, ty)), qmul(tz, tz));
            den = add_sat(ONE_Q, t2);
            sx = qdiv(add_sat(tx, tx), den);
            sy = qdiv(add_sat(ty, ty), den);
            sz = qdiv(add_sat(tz, tz), den);
            px = add_sat(mx, sub_sat(qmul(my, tz), qmul(mz, ty)));
            py = add_sat(my, sub_sat(qmul(mz, tx), qmul(mx, tz)));
            pz = add_sat(mz, sub_sat(qmul(mx, ty), qmul(my, tx)));
            ux = add_sat(mx, sub_sat(qmul(py, sz), qmul(pz, sy)));
            uy = add_sat(my, sub_sat(qmul(pz, sx), qmul(px, sz)));
            uz = add_sat(mz, sub_sat(qmul(px, sy), qmul(py, sx)));
            particle.vx = add_sat(ux, kex);
            particle.vy = add_sat(uy, key);
            particle.vz = add_sat(uz, kez);
            particle.x = add_sat(particle.x, qmul(particle.vx, dt_reg));
            particle.y = add_sat(particle.y, qmul(particle.vy, dt_reg));
            particle.z = add_sat(particle.z, qmul(particle.vz, dt_reg));
        end
        state_queue.insert(state_queue.size(), particle);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [63:0] rand_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return v;
            1: return SMAX;
            2: return SMIN;
            3: return {{34{v[63]}}, v[29:0]};
            default: return {{30{v[63]}}, v[33:0]};
        endcase
    endfunction

    task automatic send_req(input t_cmd cmd, input logic [63:0] f[6]);
        // wait a random gap after the previous request was dropped
        repeat (gap_len() + 1) @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {f[5], f[4], f[3], f[2], f[1], f[0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_push(cmd, f);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (state_queue.size() != 0) @(posedge i_clk);
    endtask

    // receiver with random stalls
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_particle got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (state_queue.size() == 0) begin
                $error("unexpected result %h", o_m_tdata);
                errors++;
            end else begin
                want = state_queue.pop_front();
                if (got.x != want.x) begin
                    $error("out_x exp %h got %h", want.x, got.x); errors++;
                end
                if (got.y != want.y) begin
                    $error("out_y exp %h got %h", want.y, got.y); errors++;
                end
                if (got.z != want.z) begin
                    $error("out_z exp %h got %h", want.z, got.z); errors++;
                end
                if (got.vx != want.vx) begin
                    $error("out_vx exp %h got %h", want.vx, got.vx); errors++;
                end
                if (got.vy != want.vy) begin
                    $error("out_vy exp %h got %h", want.vy, got.vy); errors++;
                end
                if (got.vz != want.vz) begin
                    $error("out_vz exp %h got %h", want.vz, got.vz); errors++;
                end
            end
        end
    end

    // hand-computed rows check the predictor itself
    t_req_row directed[$];

    task automatic add_row(input t_cmd c, input logic [63:0] a, input logic [63:0] b,
                           input logic has, input t_particle e);
        t_req_row r;
        r.cmd = c;
        r.f = '{a, b, b, a, b, a};
        r.has_exp = has;
        r.exp_state = e;
        directed.insert(directed.size(), r);
    endtask

    initial begin
        t_particle zero_p;
        logic [63:0] fr[6];
        zero_p = '0;
        k_reg = '0; dt_reg = '0;
        foreach (start_reg[i]) start_reg[i] = '0;
        particle = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // with k zero after reset nothing moves
        add_row(CMD_STEP, SMAX, SMIN, 1'b1, zero_p);
        add_row(CMD_STEP, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, zero_p);
        add_row(CMD_RESTART, SMAX, SMAX, 1'b1, zero_p);
        foreach (directed[i]) begin
            send_req(directed[i].cmd, directed[i].f);
            if (directed[i].has_exp && particle != directed[i].exp_state) begin
                $error("predictor exp %h got %h", directed[i].exp_state, particle);
                errors++;
            end
        end
        drain();

        // extremes (saturating k, dt and start state) first, then random registers
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(R_K, SMAX); write_reg(R_DT, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(R_SX, SMAX); write_reg(R_SY, SMIN); write_reg(R_SZ, 64'd0);
                    write_reg(R_SVX, SMAX); write_reg(R_SVY, SMIN);
                    write_reg(R_SVZ, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                1: begin
                    write_reg(R_K, SMIN); write_reg(R_DT, 64'd0);
                end
                default: begin
                    write_reg(R_K, {{34{1'b0}}, 30'($urandom)} ^ ($urandom_range(0, 1) ?
                              64'hFFFF_FFFF_C000_0000 : 64'd0));
                    write_reg(R_DT, {32'd0, $urandom});
                    write_reg(R_SX, rand_val()); write_reg(R_SY, rand_val());
                    write_reg(R_SZ, rand_val()); write_reg(R_SVX, rand_val());
                    write_reg(R_SVY, rand_val()); write_reg(R_SVZ, rand_val());
                end
            endcase
            send_req(CMD_RESTART, '{default: 64'd0});
            for (int n = 0; n < ((ph < 2) ? 8 : 120); n++) begin
                foreach (fr[j]) fr[j] = rand_val();
                send_req(($urandom_range(0, 9) == 0) ? CMD_RESTART : CMD_STEP, fr);
            end
            drain();
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
